/* design/qte_pkg.sv */
// shared types, constants and the cordic arctangent table for quaternion_to_euler
// no dependencies

package qte_pkg;

   // quaternion products are Q2.30, sums and doubled sums need 34 bits
   localparam int PROD_W = 32;
   localparam int SUM_W  = 34;

   // unit value at scale 2^30 and its negative
   localparam logic signed [SUM_W-1:0] ONE_Q30     = 34'sh0_4000_0000;
   localparam logic signed [SUM_W-1:0] NEG_ONE_Q30 = -34'sh0_4000_0000;

   // square root: radicand up to 2^60, one result bit per stage
   localparam int SQRT_IN_W  = 61;
   localparam int SQRT_ACC_W = 62;
   localparam int SQRT_STEPS = 31;
   localparam int ROOT_W     = 31;

   // quarter turn in 16-bit binary angle
   localparam logic signed [15:0] QUARTER_POS = 16'sd16384;
   localparam logic signed [15:0] QUARTER_NEG = -16'sd16384;

   // pitch sideband carried alongside the square root
   typedef struct packed {
      logic signed [SUM_W-1:0] sr;
      logic signed [SUM_W-1:0] cr;
      logic signed [SUM_W-1:0] sp;
      logic signed [SUM_W-1:0] sy;
      logic signed [SUM_W-1:0] cy;
      logic                    clamp;
      logic                    neg;
   } side_type;

   typedef struct packed {
      logic clamp;
      logic neg;
   } pflag_type;

   // atan(2^-i) with a full turn at 2^32
   function automatic logic [31:0] atan_entry(input logic [4:0] idx);
      logic [31:0] r;
      unique case (idx)
         5'd0:  r = 32'h20000000;
         5'd1:  r = 32'h12E4051E;
         5'd2:  r = 32'h09FB385B;
         5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;
         5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;
         5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;
         5'd9:  r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98;
         5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;
         5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2FA;
         5'd15: r = 32'h0000517D;
         5'd16: r = 32'h000028BE;
         5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A30;
         5'd19: r = 32'h00000518;
         5'd20: r = 32'h0000028C;
         5'd21: r = 32'h00000146;
         5'd22: r = 32'h000000A3;
         5'd23: r = 32'h00000051;
         5'd24: r = 32'h00000029;
         5'd25: r = 32'h00000014;
         5'd26: r = 32'h0000000A;
         5'd27: r = 32'h00000005;
         5'd28: r = 32'h00000003;
         5'd29: r = 32'h00000001;
         5'd30: r = 32'h00000001;
         default: r = 32'h00000000;
      endcase
      return r;
   endfunction

endpackage

/* design/qte_isqrt.sv */
// pipelined integer square root, one result bit per stage
// depends on qte_pkg

module qte_isqrt (
   input  logic                          clock,
   input  logic                          enable,
   input  logic [qte_pkg::SQRT_IN_W-1:0] value_i,
   output logic [qte_pkg::ROOT_W-1:0]    root_o
);
   import qte_pkg::*;

   logic [SQRT_ACC_W-1:0] rem_ff [SQRT_STEPS];
   logic [SQRT_ACC_W-1:0] res_ff [SQRT_STEPS];

   genvar k;
   generate
      for (k = 0; k < SQRT_STEPS; k++) begin : g_step
         localparam logic [SQRT_ACC_W-1:0] BIT = SQRT_ACC_W'(1) << (60 - 2 * k);
         logic [SQRT_ACC_W-1:0] rem_prev, res_prev, trial, rem_in, res_in;

         if (k == 0) begin : g_first
            assign rem_prev = SQRT_ACC_W'(value_i);
            assign res_prev = '0;
         end else begin : g_next
            assign rem_prev = rem_ff[k-1];
            assign res_prev = res_ff[k-1];
         end

         // compare and subtract for one root bit
         always_comb begin
            trial = res_prev + BIT;
            if (rem_prev >= trial) begin
               rem_in = rem_prev - trial;
               res_in = (res_prev >> 1) + BIT;
            end else begin
               rem_in = rem_prev;
               res_in = res_prev >> 1;
            end
         end

         always_ff @(posedge clock) begin
            if (enable) begin
               rem_ff[k] <= rem_in;
               res_ff[k] <= res_in;
            end
         end
      end
   endgenerate

   assign root_o = res_ff[SQRT_STEPS-1][ROOT_W-1:0];

endmodule

/* design/qte_cordic.sv */
// pipelined vectoring cordic arctangent giving a 16-bit binary angle
// depends on qte_pkg

module qte_cordic #(
   parameter int CORDIC_STAGES = 16,
   parameter int DATA_WIDTH    = 16
) (
   input  logic                             clock,
   input  logic                             enable,
   input  logic signed [qte_pkg::SUM_W-1:0] y_i,
   input  logic signed [qte_pkg::SUM_W-1:0] x_i,
   output logic        [15:0]               angle_o
);
   import qte_pkg::*;

   localparam int SHIFT = 32 - DATA_WIDTH;
   localparam int PW    = DATA_WIDTH + 2;
   localparam int CW    = DATA_WIDTH + 4;

   logic signed [CW-1:0] x_ff [CORDIC_STAGES+1];
   logic signed [CW-1:0] y_ff [CORDIC_STAGES+1];
   logic        [31:0]   z_ff [CORDIC_STAGES+1];
   logic                 zero_ff [CORDIC_STAGES+1];
   logic        [15:0]   angle_ff;

   // prescale, fold left half plane, detect the zero vector
   logic signed [PW-1:0] xs, ys;
   logic signed [CW-1:0] xe, ye;
   assign xs = PW'(x_i >>> SHIFT);
   assign ys = PW'(y_i >>> SHIFT);
   assign xe = CW'(xs);
   assign ye = CW'(ys);

   always_ff @(posedge clock) begin
      if (enable) begin
         zero_ff[0] <= (xe == '0) && (ye == '0);
         if (xe < 0) begin
            x_ff[0] <= -xe;
            y_ff[0] <= -ye;
            z_ff[0] <= 32'h80000000;
         end else begin
            x_ff[0] <= xe;
            y_ff[0] <= ye;
            z_ff[0] <= '0;
         end
      end
   end

   genvar i;
   generate
      for (i = 0; i < CORDIC_STAGES; i++) begin : g_stage
         logic signed [CW-1:0] dx, dy;
         assign dx = x_ff[i] >>> i;
         assign dy = y_ff[i] >>> i;

         // rotate toward the x axis
         always_ff @(posedge clock) begin
            if (enable) begin
               zero_ff[i+1] <= zero_ff[i];
               if (y_ff[i] >= 0) begin
                  x_ff[i+1] <= x_ff[i] + dy;
                  y_ff[i+1] <= y_ff[i] - dx;
                  z_ff[i+1] <= z_ff[i] + atan_entry(5'(i));
               end else begin
                  x_ff[i+1] <= x_ff[i] - dy;
                  y_ff[i+1] <= y_ff[i] + dx;
                  z_ff[i+1] <= z_ff[i] - atan_entry(5'(i));
               end
            end
         end
      end
   endgenerate

   // round the accumulator to 16 bits
   logic [31:0] z_round;
   assign z_round = z_ff[CORDIC_STAGES] + 32'h00008000;

   always_ff @(posedge clock) begin
      if (enable) begin
         angle_ff <= zero_ff[CORDIC_STAGES] ? 16'h0000 : z_round[31:16];
      end
   end

   assign angle_o = angle_ff;

endmodule

/* design/quaternion_to_euler.sv */
// top level: quaternion to zyx euler angles, fully pipelined
// depends on qte_pkg, qte_isqrt and qte_cordic
//
// Usage
//   Input channel req_*: one quaternion (qw, qx, qy, qz, signed Q1.15) per
//   transfer. Result channel rsp_*: roll, pitch, yaw as 16-bit binary angles
//   (32768 is pi) and pitch_clamped, one result per input.
//   The pipeline has four stages of products, sums, pitch square and
//   radicand, 31 square root stages, CORDIC_STAGES + 2 cordic stages, and
//   the output register. Throughput is one transfer per cycle while the
//   receiver keeps up; the three arctangents run in parallel cordic
//   pipelines and the square root retires one bit per stage.
//   When the receiver stalls with a result waiting, the whole pipeline holds;
//   req_ready drops until that result is taken. Bubbles flow through without
//   stopping the pipe.
//   Reset clears all valid bits; no result is presented after reset until an
//   input has travelled through the pipeline.

module quaternion_to_euler #(
   parameter int CORDIC_STAGES = 16,
   parameter int DATA_WIDTH    = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_qw,
   input  logic signed [15:0] req_qx,
   input  logic signed [15:0] req_qy,
   input  logic signed [15:0] req_qz,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_roll_angle,
   output logic signed [15:0] rsp_pitch_angle,
   output logic signed [15:0] rsp_yaw_angle,
   output logic               rsp_pitch_clamped
);
   import qte_pkg::*;

   localparam int CORDIC_LAT = CORDIC_STAGES + 2;
   localparam int SIDE_DEPTH = SQRT_STEPS + 2;
   localparam int DEPTH      = 4 + SQRT_STEPS + CORDIC_LAT + 1;

   logic advance;
   logic [DEPTH-1:0] valid_ff;
   logic [DEPTH-1:0] valid_in;

   // pipeline moves whenever the output slot is free or being drained
   assign advance   = !valid_ff[DEPTH-1] || rsp_ready;
   assign req_ready = advance;
   assign valid_in  = {valid_ff[DEPTH-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   // stage 1: quaternion products
   logic signed [PROD_W-1:0] wx_ff, yz_ff, xx_ff, yy_ff, wy_ff, zx_ff, wz_ff, xy_ff, zz_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         wx_ff <= req_qw * req_qx;
         yz_ff <= req_qy * req_qz;
         xx_ff <= req_qx * req_qx;
         yy_ff <= req_qy * req_qy;
         wy_ff <= req_qw * req_qy;
         zx_ff <= req_qz * req_qx;
         wz_ff <= req_qw * req_qz;
         xy_ff <= req_qx * req_qy;
         zz_ff <= req_qz * req_qz;
      end
   end

   // stage 2: sines and cosines at scale 2^30
   logic signed [SUM_W-1:0] sr_ff, cr_ff, sp_ff, sy_ff, cy_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         sr_ff <= (SUM_W'(wx_ff) + SUM_W'(yz_ff)) <<< 1;
         cr_ff <= ONE_Q30 - ((SUM_W'(xx_ff) + SUM_W'(yy_ff)) <<< 1);
         sp_ff <= (SUM_W'(wy_ff) - SUM_W'(zx_ff)) <<< 1;
         sy_ff <= (SUM_W'(wz_ff) + SUM_W'(xy_ff)) <<< 1;
         cy_ff <= ONE_Q30 - ((SUM_W'(yy_ff) + SUM_W'(zz_ff)) <<< 1);
      end
   end

   // stage 3: pitch sine squared, clamp detection
   logic [SUM_W-1:0] sp_mag;
   logic [59:0]      sq_in;
   logic [59:0]      sq_ff;
   side_type         side_ff [SIDE_DEPTH];
   side_type         side_in;

   assign sp_mag = sp_ff[SUM_W-1] ? SUM_W'(-sp_ff) : SUM_W'(sp_ff);
   assign sq_in  = sp_mag[29:0] * sp_mag[29:0];

   always_comb begin
      side_in.sr    = sr_ff;
      side_in.cr    = cr_ff;
      side_in.sp    = sp_ff;
      side_in.sy    = sy_ff;
      side_in.cy    = cy_ff;
      side_in.clamp = (sp_ff >= ONE_Q30) || (sp_ff <= NEG_ONE_Q30);
      side_in.neg   = sp_ff[SUM_W-1];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sq_ff      <= sq_in;
         side_ff[0] <= side_in;
      end
   end

   // stage 4: radicand 1 - s^2, then sideband delay along the square root
   logic [SQRT_IN_W-1:0] rad_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         rad_ff <= (SQRT_IN_W'(1) << 60) - SQRT_IN_W'(sq_ff);
         for (int j = 1; j < SIDE_DEPTH; j++) begin
            side_ff[j] <= side_ff[j-1];
         end
      end
   end

   logic [ROOT_W-1:0] root;

   qte_isqrt u_isqrt (
      .clock   (clock),
      .enable  (advance),
      .value_i (rad_ff),
      .root_o  (root)
   );

   // three arctangents in parallel
   logic [15:0] roll_ang, pitch_ang, yaw_ang;
   side_type    side_last;
   assign side_last = side_ff[SIDE_DEPTH-1];

   qte_cordic #(.CORDIC_STAGES(CORDIC_STAGES), .DATA_WIDTH(DATA_WIDTH)) u_roll (
      .clock   (clock),
      .enable  (advance),
      .y_i     (side_last.sr),
      .x_i     (side_last.cr),
      .angle_o (roll_ang)
   );

   qte_cordic #(.CORDIC_STAGES(CORDIC_STAGES), .DATA_WIDTH(DATA_WIDTH)) u_pitch (
      .clock   (clock),
      .enable  (advance),
      .y_i     (side_last.sp),
      .x_i     ($signed(SUM_W'(root))),
      .angle_o (pitch_ang)
   );

   qte_cordic #(.CORDIC_STAGES(CORDIC_STAGES), .DATA_WIDTH(DATA_WIDTH)) u_yaw (
      .clock   (clock),
      .enable  (advance),
      .y_i     (side_last.sy),
      .x_i     (side_last.cy),
      .angle_o (yaw_ang)
   );

   // pitch flags ride along the cordic latency
   pflag_type pflag_ff [CORDIC_LAT];

   always_ff @(posedge clock) begin
      if (advance) begin
         pflag_ff[0].clamp <= side_last.clamp;
         pflag_ff[0].neg   <= side_last.neg;
         for (int j = 1; j < CORDIC_LAT; j++) begin
            pflag_ff[j] <= pflag_ff[j-1];
         end
      end
   end

   // output stage: pitch clamping and result register
   logic signed [15:0] pitch_raw, pitch_in;
   logic signed [15:0] roll_ff, pitch_ff, yaw_ff;
   logic               clamped_ff;
   pflag_type          pflag_last;

   assign pflag_last = pflag_ff[CORDIC_LAT-1];
   assign pitch_raw  = $signed(pitch_ang);

   always_comb begin
      priority if (pflag_last.clamp) begin
         pitch_in = pflag_last.neg ? QUARTER_NEG : QUARTER_POS;
      end else if (pitch_raw > QUARTER_POS) begin
         pitch_in = QUARTER_POS;
      end else if (pitch_raw < QUARTER_NEG) begin
         pitch_in = QUARTER_NEG;
      end else begin
         pitch_in = pitch_raw;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         roll_ff    <= $signed(roll_ang);
         pitch_ff   <= pitch_in;
         yaw_ff     <= $signed(yaw_ang);
         clamped_ff <= pflag_last.clamp;
      end
   end

   assign rsp_valid         = valid_ff[DEPTH-1];
   assign rsp_roll_angle    = roll_ff;
   assign rsp_pitch_angle   = pitch_ff;
   assign rsp_yaw_angle     = yaw_ff;
   assign rsp_pitch_clamped = clamped_ff;

`ifndef SYNTHESIS
   // pitch never leaves the quarter-turn range
   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pitch_angle <= QUARTER_POS) && (rsp_pitch_angle >= QUARTER_NEG))
      else $error("pitch out of range");

   // a clamped pitch is exactly a quarter turn
   a_clamp_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_pitch_clamped) |->
         (rsp_pitch_angle == QUARTER_POS) || (rsp_pitch_angle == QUARTER_NEG))
      else $error("clamped pitch not a quarter turn");

   // a stalled result keeps its angles
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_roll_angle)
         && $stable(rsp_yaw_angle) && $stable(rsp_pitch_angle))
      else $error("result changed during stall");

   // pipeline is empty after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");
`endif

endmodule

/* verif/quaternion_to_euler_checker.sv */
// result checker for quaternion_to_euler: watches both channels, predicts angles
// depends on nothing outside this file; pairs with quaternion_to_euler_tb

`timescale 1ns / 1ps

module quaternion_to_euler_checker #(
   parameter int CORDIC_STAGES = 16,
   parameter int DATA_WIDTH    = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic signed [15:0] req_qw,
   input  logic signed [15:0] req_qx,
   input  logic signed [15:0] req_qy,
   input  logic signed [15:0] req_qz,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [15:0] rsp_roll_angle,
   input  logic signed [15:0] rsp_pitch_angle,
   input  logic signed [15:0] rsp_yaw_angle,
   input  logic               rsp_pitch_clamped,
   output int                 error_count,
   output int                 angles_pending
);

   typedef struct packed {
      logic signed [15:0] roll;
      logic signed [15:0] pitch;
      logic signed [15:0] yaw;
      logic               clamped;
   } euler_type;

   euler_type euler_queue[$];

   localparam longint UNIT_Q30 = 64'sd1 << 30;

   // atan(2^-i), full turn at 2^32
   function automatic logic [31:0] atan_step(input int i);
      logic [31:0] steps [32];
      steps = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
                32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
                32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
                32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
                32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
                32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
                32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
                32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000};
      return steps[i & 31];
   endfunction

   // vectoring arctangent, returns rounded 16-bit binary angle
   function automatic logic [15:0] vector_angle(input longint sy, input longint sx);
      longint vy, vx, dx, dy;
      logic [31:0] acc;
      vy = sy >>> (32 - DATA_WIDTH);
      vx = sx >>> (32 - DATA_WIDTH);
      acc = 0;
      if (vx == 0 && vy == 0) return 16'd0;
      if (vx < 0) begin
         vx = -vx;
         vy = -vy;
         acc = 32'h80000000;
      end
      for (int i = 0; i < CORDIC_STAGES; i++) begin
         dx = vx >>> (i & 31);
         dy = vy >>> (i & 31);
         if (vy >= 0) begin
            vx += dy;
            vy -= dx;
            acc += atan_step(i);
         end else begin
            vx -= dy;
            vy += dx;
            acc -= atan_step(i);
         end
      end
      acc = acc + 32'h8000;
      return acc[31:16];
   endfunction

   function automatic longint floor_sqrt(input longint unsigned v);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   function automatic euler_type predict_euler(input logic signed [15:0] qw,
         input logic signed [15:0] qx, input logic signed [15:0] qy,
         input logic signed [15:0] qz);
      longint w, x, y, z, sr, cr, sp, sy, cy, cp, p;
      euler_type e;
      w = qw; x = qx; y = qy; z = qz;
      sr = 2 * (w * x + y * z);
      cr = UNIT_Q30 - 2 * (x * x + y * y);
      sp = 2 * (w * y - z * x);
      sy = 2 * (w * z + x * y);
      cy = UNIT_Q30 - 2 * (y * y + z * z);
      e.clamped = 1'b0;
      if (sp >= UNIT_Q30) begin
         e.pitch = 16'sd16384;
         e.clamped = 1'b1;
      end else if (sp <= -UNIT_Q30) begin
         e.pitch = -16'sd16384;
         e.clamped = 1'b1;
      end else begin
         cp = floor_sqrt((64'd1 << 60) - longint'(sp * sp));
         p = longint'($signed(vector_angle(sp, cp)));
         if (p > 16384) p = 16384;
         if (p < -16384) p = -16384;
         e.pitch = p[15:0];
      end
      e.roll = vector_angle(sr, cr);
      e.yaw = vector_angle(sy, cy);
      return e;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   assign angles_pending = euler_queue.size();

   initial error_count = 0;

   // predict on input transfer, compare on result transfer
   always @(posedge clock) begin
      euler_type want;
      if (!reset) begin
         if (req_valid && req_ready)
            euler_queue.push_back(predict_euler(req_qw, req_qx, req_qy, req_qz));
         if (rsp_valid && rsp_ready) begin
            if (euler_queue.size() == 0) begin
               report_mismatch("unexpected result", 0, 0);
            end else begin
               want = euler_queue.pop_front();
               if (rsp_roll_angle !== want.roll)
                  report_mismatch("roll", rsp_roll_angle, want.roll);
               if (rsp_pitch_angle !== want.pitch)
                  report_mismatch("pitch", rsp_pitch_angle, want.pitch);
               if (rsp_yaw_angle !== want.yaw)
                  report_mismatch("yaw", rsp_yaw_angle, want.yaw);
               if (rsp_pitch_clamped !== want.clamped)
                  report_mismatch("pitch_clamped", rsp_pitch_clamped, want.clamped);
            end
         end
      end
   end

endmodule

/* verif/quaternion_to_euler_tb.sv */
// testbench top for quaternion_to_euler: clock, reset, stimulus and verdict
// depends on quaternion_to_euler and quaternion_to_euler_checker

`timescale 1ns / 1ps

module quaternion_to_euler_tb;

   localparam int LATENCY     = 54;
   localparam int CYCLE_LIMIT = 200000;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic signed [15:0] req_qw, req_qx, req_qy, req_qz;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [15:0] rsp_roll_angle, rsp_pitch_angle, rsp_yaw_angle;
   logic               rsp_pitch_clamped;
   int                 error_count;
   int                 angles_pending;
   int                 cycle_count;
   logic               calm_phase;
   logic               hold_request;
   logic               hold_done;

   quaternion_to_euler u_dut (.*);

   quaternion_to_euler_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // result side: random stalls, one long hold-off mid-stream, none in the calm phase
   initial begin
      rsp_ready = 1'b0;
      hold_done = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      repeat (60) @(negedge clock);
      forever begin
         if (hold_request && !hold_done) begin
            rsp_ready <= 1'b0;
            repeat (150) @(negedge clock);
            hold_done = 1'b1;
         end else begin
            rsp_ready <= calm_phase ? 1'b1 : ($urandom_range(99) >= 36);
            @(negedge clock);
         end
      end
   end

   task automatic send_quat(input logic [15:0] w, input logic [15:0] x,
         input logic [15:0] y, input logic [15:0] z);
      while (!calm_phase && $urandom_range(99) < 36) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_qw <= w; req_qx <= x; req_qy <= y; req_qz <= z;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // roughly unit quaternion from four random components, normalized
   task automatic send_unit_quat();
      real a, b, c, d, n;
      a = $urandom_range(65535) - 32768.0;
      b = $urandom_range(65535) - 32768.0;
      c = $urandom_range(65535) - 32768.0;
      d = $urandom_range(65535) - 32768.0;
      n = $sqrt(a * a + b * b + c * c + d * d) + 1.0;
      send_quat(16'(int'(a / n * 32767.0)), 16'(int'(b / n * 32767.0)),
                16'(int'(c / n * 32767.0)), 16'(int'(d / n * 32767.0)));
   endtask

   initial begin
      int pick;
      cycle_count = 0;
      calm_phase = 1'b0;
      hold_request = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_qw = '0; req_qx = '0; req_qy = '0; req_qz = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: identity, zeros, extremes, gimbal lock both ways
      send_quat(16'h7FFF, 16'h0000, 16'h0000, 16'h0000);
      send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_quat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_quat(16'h5A82, 16'h0000, 16'h5A82, 16'h0000);
      send_quat(16'h5A82, 16'h0000, 16'hA57E, 16'h0000);
      send_quat(16'h5A82, 16'h5A82, 16'h0000, 16'h0000);
      send_quat(16'h5A82, 16'h0000, 16'h0000, 16'h5A82);
      send_quat(16'h0000, 16'h7FFF, 16'h0000, 16'h0000);
      send_quat(16'h0000, 16'h0000, 16'h7FFF, 16'h0000);
      send_quat(16'h0000, 16'h0000, 16'h0000, 16'h7FFF);
      send_quat(16'h5A81, 16'h0000, 16'h5A81, 16'h0000);
      send_quat(16'h5A80, 16'h0040, 16'h5A80, 16'hFFC0);
      send_quat(16'h8000, 16'h0000, 16'h8000, 16'h0000);
      send_quat(16'h4000, 16'hC000, 16'h4000, 16'h4000);
      send_quat(16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF);
      send_quat(16'h7FFF, 16'h0000, 16'h8000, 16'h0000);
      send_quat(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
      send_quat(16'h0000, 16'h7FFF, 16'h0000, 16'h7FFF);
      send_quat(16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000);
      req_valid <= 1'b0;

      // pause until every result has been taken
      while (angles_pending != 0) @(negedge clock);

      // random: mostly unit quaternions, some raw noise, a calm stretch
      for (int n = 0; n < 430; n++) begin
         if (n == 100) hold_request = 1'b1;
         calm_phase = (n >= 200 && n < 260);
         pick = $urandom_range(99);
         if (pick < 70) send_unit_quat();
         else send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      end
      req_valid <= 1'b0;
      calm_phase = 1'b0;

      while (angles_pending != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
